// ===== hdl/b64d_pkg.sv =====
`default_nettype none
package b64d_pkg;

   // Index value given to any character outside the base64 alphabet.
   localparam logic [6:0] NOT_IN_ALPHABET = 7'd100;

   // Result queue depth and the largest number of results one character can cause.
   localparam int QUEUE_DEPTH  = 6;
   localparam int MAX_RESULTS  = 3;
   localparam int COUNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] in_char;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       out_error;
   } rsp_type;

   // Results produced by one accepted character, item[0] first.
   typedef struct packed {
      logic [1:0]                  count;
      rsp_type [MAX_RESULTS-1:0]   item;
   } push_type;

   // Maps an ASCII code to its index in the standard base64 alphabet.
   function automatic logic [6:0] char_index(input logic [7:0] c);
      logic [7:0] v;
      begin
         v = {1'b0, NOT_IN_ALPHABET};
         if (c >= 8'h41 && c <= 8'h5A) begin
            v = c - 8'd65;
         end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = c - 8'd71;
         end else if (c >= 8'h30 && c <= 8'h39) begin
            v = c + 8'd4;
         end else if (c == 8'h2B) begin
            v = 8'd62;
         end else if (c == 8'h2F) begin
            v = 8'd63;
         end
         return v[6:0];
      end
   endfunction

endpackage
`default_nettype wire

// ===== hdl/b64d_group.sv =====
`default_nettype none
module b64d_group
   import b64d_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     accept,
   input  wire req_type  req,
   output push_type      push
);

   logic [6:0] vals_ff [3];
   logic [6:0] vals_in [3];
   logic [1:0] pos_ff;
   logic [1:0] pos_in;
   logic [6:0] v;
   rsp_type    b0, b1, b2;

   assign v = char_index(req.in_char);

   always_comb begin
      vals_in = vals_ff;
      pos_in  = pos_ff;
      push    = '0;
      b0 = '{out_byte: {vals_ff[0][5:0], vals_ff[1][5:4]}, out_last: 1'b0, out_error: 1'b0};
      b1 = '{out_byte: {vals_ff[1][3:0], vals_ff[2][5:2]}, out_last: 1'b0, out_error: 1'b0};
      b2 = '{out_byte: {vals_ff[2][1:0], v[5:0]}, out_last: 1'b0, out_error: 1'b0};
      if (accept) begin
         if (pos_ff != 2'd3) begin
            if (req.in_last) begin
               // The stream ended inside a group: one error result.
               push.count   = 2'd1;
               push.item[0] = '{out_byte: 8'd0, out_last: 1'b1, out_error: 1'b1};
               vals_in      = '{default: 7'd0};
               pos_in       = 2'd0;
            end else begin
               vals_in[pos_ff] = v;
               pos_in          = pos_ff + 2'd1;
            end
         end else begin
            if (vals_ff[2] == NOT_IN_ALPHABET) begin
               b0.out_last = req.in_last;
               push.count  = 2'd1;
            end else if (v == NOT_IN_ALPHABET) begin
               b1.out_last = req.in_last;
               push.count  = 2'd2;
            end else begin
               b2.out_last = req.in_last;
               push.count  = 2'd3;
            end
            push.item[0] = b0;
            push.item[1] = b1;
            push.item[2] = b2;
            vals_in      = '{default: 7'd0};
            pos_in       = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vals_ff <= '{default: 7'd0};
         pos_ff  <= 2'd0;
      end else begin
         vals_ff <= vals_in;
         pos_ff  <= pos_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/b64d_queue.sv =====
`default_nettype none
module b64d_queue
   import b64d_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire push_type               push,
   input  wire logic                   pop,
   output rsp_type                     head,
   output logic [COUNT_WIDTH-1:0]      count
);

   rsp_type                entry_ff [QUEUE_DEPTH];
   rsp_type                entry_in [QUEUE_DEPTH];
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic [COUNT_WIDTH-1:0] base;

   assign base     = count_ff - COUNT_WIDTH'(pop);
   assign count_in = base + COUNT_WIDTH'(push.count);
   assign head     = entry_ff[0];
   assign count    = count_ff;

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && i < QUEUE_DEPTH - 1) begin
            entry_in[i] = entry_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
         end else begin
            entry_in[i] = entry_ff[i];
         end
         for (int k = 0; k < MAX_RESULTS; k++) begin
            if (2'(k) < push.count && COUNT_WIDTH'(i) == base + COUNT_WIDTH'(k)) begin
               entry_in[i] = push.item[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

// ===== hdl/base64_stream_decoder.sv =====
`default_nettype none
// Base64 stream decoder.
// The req_ channel carries one text character per transfer, with in_last set on the
// final character of a stream. The rsp_ channel carries one decoded byte per transfer.
// Every fourth character of a group releases up to three bytes: byte1 is dropped when
// the third character is outside the alphabet, byte2 when the third or fourth is.
// The last byte of a stream that ends on a group boundary carries out_last. A stream
// that ends inside a group gives a single result with out_error and out_last set and a
// zero byte; bytes already sent for earlier groups stand. Latency: when the result
// queue is empty, the results caused by a character are offered on rsp_ in the cycle
// after its transfer; otherwise they wait behind the results already queued, draining
// one per cycle while rsp_ready is high. Throughput: one character per cycle; the
// six-entry result queue keeps pace since four characters give at most three bytes.
// req_ready is high while the queue holds three entries or fewer, so a stalled
// receiver fills the queue and then holds off the sender without losing data.
// Reset clears the open group and empties the queue.
module base64_stream_decoder
   import b64d_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire req_type  req_data,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_data
);

   logic                   req_fire;
   logic                   rsp_fire;
   push_type               push;
   logic [COUNT_WIDTH-1:0] count;

   // A character may cause up to three results, so room for that many is required.
   assign req_ready = (count <= COUNT_WIDTH'(QUEUE_DEPTH - MAX_RESULTS));
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (count != '0);
   assign rsp_fire  = rsp_valid && rsp_ready;

   // Group assembly: maps characters to indices and forms the bytes of a group.
   b64d_group u_group (
      .clock  (clock),
      .reset  (reset),
      .accept (req_fire),
      .req    (req_data),
      .push   (push)
   );

   // Result queue: the head entry drives the rsp_ channel directly.
   b64d_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (rsp_fire),
      .head   (rsp_data),
      .count  (count)
   );

   // The queue never holds more than its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= COUNT_WIDTH'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // Without a result transfer the queue cannot shrink.
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      !rsp_fire |=> count >= $past(count))
      else $error("result lost from queue");

   // A result transfer with no character accepted removes exactly one entry.
   a_pop_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !req_fire) |=> count == $past(count) - COUNT_WIDTH'(1))
      else $error("queue count off after a result transfer");

   // An error result ends the stream and carries a zero byte.
   a_error_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_error) |-> (rsp_data.out_last && rsp_data.out_byte == 8'd0))
      else $error("malformed error result");

endmodule
`default_nettype wire

// ===== verif/base64_stream_decoder_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none

module base64_stream_decoder_tb;
   import b64d_pkg::*;

   // A run that stops moving data for this many cycles is treated as hung.
   localparam int IDLE_LIMIT = 2000;
   // Cycles allowed after the last expected result, for stray late results.
   localparam int DRAIN_CYCLES = 12;
   // Random characters per idle phase; with the directed characters, four phases
   // give about 160 in total.
   localparam int PHASE_CHARS = 28;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   base64_stream_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Characters waiting to be sent, and the decoded bytes that the block owes us.
   req_type pending_chars [$];
   rsp_type expected_bytes [$];

   // Percentages of cycles in which the sender holds back or the receiver stalls.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   int fail_count = 0;
   int chars_sent = 0;
   int bytes_seen = 0;
   int length_errors_seen = 0;
   int idle_cycles = 0;

   // Our own copy of the open group: the indices held so far and how many there are.
   logic [6:0] grp_val [3];
   logic [1:0] grp_pos;

   // The character at position k of the standard base64 alphabet.
   function automatic logic [7:0] alpha_char(input int k);
      if (k < 26) begin
         return 8'(8'h41 + k);
      end else if (k < 52) begin
         return 8'(8'h61 + k - 26);
      end else if (k < 62) begin
         return 8'(8'h30 + k - 52);
      end else if (k == 62) begin
         return 8'h2B;
      end
      return 8'h2F;
   endfunction

   // Index of a character in the alphabet, or the invalid mark when it is not there.
   function automatic logic [6:0] alpha_index(input logic [7:0] c);
      for (int k = 0; k < 64; k++) begin
         if (alpha_char(k) == c) begin
            return 7'(k);
         end
      end
      return NOT_IN_ALPHABET;
   endfunction

   // Works out which bytes one accepted character releases and queues them in order.
   task automatic predict_bytes(input req_type r);
      logic [6:0] v;
      logic [7:0] b [3];
      int         n;
      rsp_type    e;
      v = alpha_index(r.in_char);
      n = 0;
      if (grp_pos < 2'd3) begin
         if (r.in_last) begin
            // The stream ended inside a group: the character is dropped and a
            // single zero byte flagged as a length error closes the stream.
            e.out_byte  = 8'h00;
            e.out_last  = 1'b1;
            e.out_error = 1'b1;
            expected_bytes.push_back(e);
            grp_val = '{default: 7'd0};
            grp_pos = 2'd0;
         end else begin
            grp_val[grp_pos] = v;
            grp_pos = grp_pos + 2'd1;
         end
      end else begin
         // Fourth character of the group. The shifts keep only what survives the
         // reduction to eight bits, so an invalid v0 or v1 still feeds its low bits.
         b[0] = {grp_val[0][5:0], grp_val[1][5:4]};
         b[1] = {grp_val[1][3:0], grp_val[2][5:2]};
         b[2] = {grp_val[2][1:0], v[5:0]};
         n = 1;
         if (grp_val[2] != NOT_IN_ALPHABET) begin
            n = (v != NOT_IN_ALPHABET) ? 3 : 2;
         end
         for (int k = 0; k < n; k++) begin
            e.out_byte  = b[k];
            e.out_last  = r.in_last && (k == n - 1);
            e.out_error = 1'b0;
            expected_bytes.push_back(e);
         end
         grp_val = '{default: 7'd0};
         grp_pos = 2'd0;
      end
   endtask

   // Sender. A character stays on the bus until it is taken; only then may the next
   // one be offered, or the bus go idle for a while.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         grp_val = '{default: 7'd0};
         grp_pos = 2'd0;
      end else begin
         if (req_valid && req_ready) begin
            predict_bytes(req_data);
            chars_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_chars.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver. Every transfer on the result side is matched against the oldest
   // expected byte, field by field.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            bytes_seen++;
            if (rsp_data.out_error) begin
               length_errors_seen++;
            end
            if (expected_bytes.size() == 0) begin
               $error("unexpected result: out_byte %02h out_last %0b out_error %0b",
                      rsp_data.out_byte, rsp_data.out_last, rsp_data.out_error);
               fail_count++;
            end else begin
               rsp_type e;
               e = expected_bytes.pop_front();
               if (rsp_data.out_byte !== e.out_byte) begin
                  $error("out_byte: expected %02h, actual %02h", e.out_byte, rsp_data.out_byte);
                  fail_count++;
               end
               if (rsp_data.out_last !== e.out_last) begin
                  $error("out_last: expected %0b, actual %0b", e.out_last, rsp_data.out_last);
                  fail_count++;
               end
               if (rsp_data.out_error !== e.out_error) begin
                  $error("out_error: expected %0b, actual %0b",
                         e.out_error, rsp_data.out_error);
                  fail_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: counts cycles in which neither channel completes a transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d bytes still owed",
                     IDLE_LIMIT, expected_bytes.size());
            $display("** base64_stream_decoder: FAILED **");
            $finish;
         end
      end
   end

   task automatic add_char(input logic [7:0] c, input logic last);
      req_type r;
      r.in_char = c;
      r.in_last = last;
      pending_chars.push_back(r);
   endtask

   // Queues a text string; the final character carries in_last when asked.
   task automatic add_text(input string s, input logic last_at_end);
      for (int i = 0; i < s.len(); i++) begin
         add_char(s[i], last_at_end && (i == s.len() - 1));
      end
   endtask

   // One random stream. Most streams are well formed, with optional padding at
   // the end; some end inside a group; a few are raw noise bytes.
   task automatic add_random_stream(output int n_chars);
      int kind;
      int n_pads;
      int total;
      logic [7:0] c;
      logic with_last;
      kind  = $urandom_range(99);
      total = 4 * $urandom_range(1, 4);
      n_pads = 0;
      with_last = 1'b1;
      if (kind < 70) begin
         n_pads = $urandom_range(0, 2);
         // Now and then a whole stream runs on into the next one.
         with_last = ($urandom_range(9) != 0);
      end else if (kind < 88) begin
         total = total - $urandom_range(1, 3);
      end
      for (int i = 0; i < total; i++) begin
         if (kind >= 88 || $urandom_range(19) == 0) begin
            c = 8'($urandom_range(255));
         end else if (i >= total - n_pads) begin
            c = 8'h3D;
         end else begin
            c = alpha_char($urandom_range(63));
         end
         add_char(c, with_last && (i == total - 1));
      end
      n_chars = total;
   endtask

   // Waits until every queued character has gone and every owed byte has come.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_chars.size() != 0 || req_valid || expected_bytes.size() != 0);
   endtask

   initial begin
      int added;
      int n;
      int send_pct [4];
      int recv_pct [4];

      send_pct = '{0, 57, 0, 14};
      recv_pct = '{0, 0, 57, 14};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, sent with no idling on either side.
      // A plain group whose last character ends the stream.
      add_text("TWFu", 1'b1);
      // Two pad characters: the third is invalid, so only the first byte comes.
      add_text("TQ==", 1'b1);
      // Codes outside the alphabet in the first two places still feed byte0 and
      // byte1; a valid third and an invalid fourth give exactly two bytes.
      add_char(8'hFF, 1'b0);
      add_char(8'h00, 1'b0);
      add_char(8'h41, 1'b0);
      add_char(8'h3D, 1'b1);
      // All-ones and near-extreme indices, over two groups of one stream.
      add_text("////", 1'b0);
      add_text("+AB9", 1'b1);
      // Streams that end after one, two and three characters of a group.
      add_text("z", 1'b1);
      add_text("09", 1'b1);
      add_text("ab+", 1'b1);
      wait_drained();

      // Random part, in four idle phases. The sender pauses at every phase
      // boundary until the block has handed over everything it owes.
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = send_pct[p];
         recv_stall_pct = recv_pct[p];
         added = 0;
         while (added < PHASE_CHARS) begin
            add_random_stream(n);
            added += n;
         end
         // A stream left open at the end of a phase is closed with a lone
         // terminating character so that the next phase starts clean.
         add_char(alpha_char($urandom_range(63)), 1'b1);
         wait_drained();
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_bytes.size() != 0) begin
         $error("%0d expected bytes never arrived", expected_bytes.size());
         fail_count++;
      end

      $display("Sent %0d characters in directed and four random idle phases;",
               chars_sent);
      $display("received %0d results, %0d of them length errors, with %0d mismatches.",
               bytes_seen, length_errors_seen, fail_count);
      if (fail_count == 0) begin
         $display("** base64_stream_decoder: PASSED **");
      end else begin
         $display("** base64_stream_decoder: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
